>>> rtl/core/assert_macros.svh
// Assertion macros for the checker module of this block.
// Stand-alone header; the file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sfpc_pkg.sv
// Types, codes and helper functions of the size filter parser and comparator.
// No dependencies; every other file of the block but the assertion header imports this package.
package sfpc_pkg;

	typedef struct packed {
		logic        opcode;
		logic [15:0] text_unit;
		logic        text_end;
		logic [63:0] file_size;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       matches_res;
	} rsp_t;

	localparam logic OP_TEXT    = 1'b0;
	localparam logic OP_COMPARE = 1'b1;

	typedef enum logic [1:0] {
		ST_ACCEPT    = 2'd0,
		ST_REJECT    = 2'd1,
		ST_COMPARED  = 2'd2,
		ST_NO_FILTER = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_START      = 5'b00001,
		PH_PREFIX1    = 5'b00010,
		PH_NEED_DIGIT = 5'b00100,
		PH_DIGITS     = 5'b01000,
		PH_UNIT       = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		MODE_EQ          = 3'd0,
		MODE_EQ_EXPLICIT = 3'd1,
		MODE_GT          = 3'd2,
		MODE_GE          = 3'd3,
		MODE_LT          = 3'd4,
		MODE_LE          = 3'd5,
		MODE_RANGE       = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		SUF_NONE = 3'd0,
		SUF_B    = 3'd1,
		SUF_K    = 3'd2,
		SUF_M    = 3'd3,
		SUF_G    = 3'd4,
		SUF_KB   = 3'd5,
		SUF_MB   = 3'd6,
		SUF_GB   = 3'd7
	} suffix_t;

	// The active filter as the comparator sees it.
	typedef struct packed {
		logic        loaded;
		mode_t       mode;
		logic [63:0] low;
		logic [63:0] high;
	} filt_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
	} scaled_t;

	localparam logic [15:0] CH_DOT  = 16'h002E;
	localparam logic [15:0] CH_LT   = 16'h003C;
	localparam logic [15:0] CH_EQ   = 16'h003D;
	localparam logic [15:0] CH_GT   = 16'h003E;
	localparam logic [15:0] CH_0    = 16'h0030;
	localparam logic [15:0] CH_9    = 16'h0039;
	localparam logic [15:0] CH_UP_A = 16'h0041;
	localparam logic [15:0] CH_UP_Z = 16'h005A;
	localparam logic [15:0] CH_B    = 16'h0062;
	localparam logic [15:0] CH_G    = 16'h0067;
	localparam logic [15:0] CH_K    = 16'h006B;
	localparam logic [15:0] CH_M    = 16'h006D;
	localparam logic [15:0] CASE_OFFSET = 16'h0020;

	localparam int KB_SHIFT = 10;
	localparam int MB_SHIFT = 20;
	localparam int GB_SHIFT = 30;

	// Applies the unit to a number. Overflow shows as nonzero bits shifted out.
	function automatic scaled_t scale_size(logic [63:0] num, suffix_t suf);
		scaled_t r;
		r.ok    = 1'b1;
		r.value = num;
		case (suf)
			SUF_NONE, SUF_B: begin
				r.ok    = 1'b1;
				r.value = num;
			end
			SUF_KB: begin
				r.ok    = ~|num[63:64-KB_SHIFT];
				r.value = num << KB_SHIFT;
			end
			SUF_MB: begin
				r.ok    = ~|num[63:64-MB_SHIFT];
				r.value = num << MB_SHIFT;
			end
			SUF_GB: begin
				r.ok    = ~|num[63:64-GB_SHIFT];
				r.value = num << GB_SHIFT;
			end
			default: begin
				r.ok    = 1'b0;
				r.value = '0;
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/sfpc_parse.sv
// Filter text parser: parse state, active filter registers and end-of-text check.
// Depends on sfpc_pkg.
module sfpc_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  sfpc_pkg::req_t item,
	output sfpc_pkg::filt_t filt,
	output logic          text_ok
);
	import sfpc_pkg::*;

	phase_t      phase_q, n_phase;
	mode_t       mode_q, n_mode;
	logic [63:0] low_q, n_low;
	logic [63:0] high_q, n_high;
	logic [63:0] accum_q, n_accum;
	suffix_t     suffix_q, n_suffix;
	logic        dot_q, n_dot;
	logic        range_q, n_range;
	logic        err_q, n_err;
	logic        loaded_q, n_loaded;

	logic [15:0] ch;
	logic [15:0] ch_low;
	logic        is_digit;
	logic [67:0] sum;
	logic        sum_ovf;
	scaled_t     split_sc;
	scaled_t     end_sc;
	logic        digit_added;
	logic        fin_ok;

	assign ch       = item.text_unit;
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign ch_low   = ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ? ch + CASE_OFFSET : ch;
	// Times ten plus the digit; anything at or above two to the 64 is overflow.
	assign sum      = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + {64'b0, ch[3:0]};
	assign sum_ovf  = |sum[67:64];
	assign split_sc = scale_size(accum_q, suffix_q);

	always_comb begin
		n_phase     = phase_q;
		n_mode      = mode_q;
		n_low       = low_q;
		n_high      = high_q;
		n_accum     = accum_q;
		n_suffix    = suffix_q;
		n_dot       = dot_q;
		n_range     = range_q;
		n_err       = err_q;
		n_loaded    = loaded_q;
		digit_added = 1'b0;
		fin_ok      = 1'b0;
		end_sc      = scale_size(accum_q, suffix_q);

		if (item.opcode == OP_TEXT) begin
			n_loaded = 1'b0;
			if (!err_q) begin
				if (dot_q) begin
					n_dot = 1'b0;
					if (ch == CH_DOT) begin
						if (!split_sc.ok) begin
							n_err = 1'b1;
						end else begin
							n_low    = split_sc.value;
							n_accum  = '0;
							n_suffix = SUF_NONE;
							n_range  = 1'b1;
							n_mode   = MODE_RANGE;
							n_phase  = PH_NEED_DIGIT;
						end
					end else begin
						n_err = 1'b1;
					end
				end else begin
					case (phase_q)
						PH_START: begin
							n_mode = MODE_EQ;
							if (ch == CH_GT) begin
								n_mode  = MODE_GT;
								n_phase = PH_PREFIX1;
							end else if (ch == CH_LT) begin
								n_mode  = MODE_LT;
								n_phase = PH_PREFIX1;
							end else if (ch == CH_EQ) begin
								n_mode  = MODE_EQ_EXPLICIT;
								n_phase = PH_NEED_DIGIT;
							end else if (is_digit) begin
								digit_added = 1'b1;
							end else begin
								n_err = 1'b1;
							end
						end
						PH_PREFIX1: begin
							if (ch == CH_EQ) begin
								n_mode  = (mode_q == MODE_GT) ? MODE_GE : MODE_LE;
								n_phase = PH_NEED_DIGIT;
							end else if (is_digit) begin
								digit_added = 1'b1;
							end else begin
								n_err = 1'b1;
							end
						end
						PH_NEED_DIGIT: begin
							if (is_digit) begin
								digit_added = 1'b1;
							end else begin
								n_err = 1'b1;
							end
						end
						PH_DIGITS, PH_UNIT: begin
							if (ch == CH_DOT) begin
								if ((mode_q == MODE_EQ) && !range_q) begin
									n_dot = 1'b1;
								end else begin
									n_err = 1'b1;
								end
							end else if (is_digit) begin
								if (phase_q == PH_DIGITS) begin
									digit_added = 1'b1;
								end else begin
									n_err = 1'b1;
								end
							end else if (suffix_q == SUF_NONE) begin
								n_phase = PH_UNIT;
								if (ch_low == CH_B) begin
									n_suffix = SUF_B;
								end else if (ch_low == CH_K) begin
									n_suffix = SUF_K;
								end else if (ch_low == CH_M) begin
									n_suffix = SUF_M;
								end else if (ch_low == CH_G) begin
									n_suffix = SUF_G;
								end else begin
									n_err   = 1'b1;
									n_phase = phase_q;
								end
							end else if ((suffix_q == SUF_K || suffix_q == SUF_M ||
									suffix_q == SUF_G) && ch_low == CH_B) begin
								n_suffix = suffix_t'(suffix_q + 3'd3);
								n_phase  = PH_UNIT;
							end else begin
								n_err = 1'b1;
							end
						end
						default: begin
							n_err = 1'b1;
						end
					endcase

					if (digit_added) begin
						if (sum_ovf) begin
							n_err       = 1'b1;
							digit_added = 1'b0;
						end else begin
							n_accum = sum[63:0];
							n_phase = PH_DIGITS;
						end
					end
				end
			end

			if (item.text_end) begin
				// A digit in this unit means no unit letter, so no scaling is needed.
				if (digit_added) begin
					end_sc.ok    = 1'b1;
					end_sc.value = sum[63:0];
				end else begin
					end_sc = scale_size(accum_q, n_suffix);
				end
				fin_ok = !n_err && !n_dot && (n_phase == PH_DIGITS || n_phase == PH_UNIT) &&
					end_sc.ok;
				if (fin_ok) begin
					if (n_range) begin
						if (low_q > end_sc.value) begin
							fin_ok = 1'b0;
						end else begin
							n_high = end_sc.value;
						end
					end else begin
						n_low  = end_sc.value;
						n_high = '0;
					end
				end
				n_loaded = fin_ok;
				n_phase  = PH_START;
				n_accum  = '0;
				n_suffix = SUF_NONE;
				n_dot    = 1'b0;
				n_range  = 1'b0;
				n_err    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			mode_q   <= MODE_EQ;
			low_q    <= '0;
			high_q   <= '0;
			accum_q  <= '0;
			suffix_q <= SUF_NONE;
			dot_q    <= 1'b0;
			range_q  <= 1'b0;
			err_q    <= 1'b0;
			loaded_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= n_phase;
			mode_q   <= n_mode;
			low_q    <= n_low;
			high_q   <= n_high;
			accum_q  <= n_accum;
			suffix_q <= n_suffix;
			dot_q    <= n_dot;
			range_q  <= n_range;
			err_q    <= n_err;
			loaded_q <= n_loaded;
		end
	end

	assign filt.loaded = loaded_q;
	assign filt.mode   = mode_q;
	assign filt.low    = low_q;
	assign filt.high   = high_q;
	assign text_ok     = fin_ok;

endmodule

>>> rtl/core/sfpc_match.sv
// Size comparator: tests one candidate size against the active filter.
// Depends on sfpc_pkg.
module sfpc_match (
	input  sfpc_pkg::filt_t filt,
	input  logic [63:0]     file_size,
	output logic            hit
);
	import sfpc_pkg::*;

	logic ge_low;
	logic le_low;
	logic eq_low;
	logic le_high;

	assign ge_low  = file_size >= filt.low;
	assign le_low  = file_size <= filt.low;
	assign eq_low  = file_size == filt.low;
	assign le_high = file_size <= filt.high;

	always_comb begin
		case (filt.mode)
			MODE_EQ, MODE_EQ_EXPLICIT: hit = eq_low;
			MODE_GT:                   hit = !le_low;
			MODE_GE:                   hit = ge_low;
			MODE_LT:                   hit = !ge_low;
			MODE_LE:                   hit = le_low;
			MODE_RANGE:                hit = ge_low && le_high;
			default:                   hit = 1'b0;
		endcase
	end

endmodule

>>> rtl/core/size_filter_parse_and_compare.sv
// Top level of the size filter parser and comparator: input register, result register.
// Depends on sfpc_pkg, sfpc_parse and sfpc_match.
//
// Usage. The req channel carries one word per item. A word with opcode 0 feeds one
// UTF-16 code unit of filter text; text_end marks the last unit of a text. A word with
// opcode 1 asks whether file_size satisfies the active filter. The rsp channel returns
// one word for each last text unit (status accepted or rejected) and for each compare
// (status compared with matches_res, or no filter loaded). Text units that are not the
// last produce no response word.
// Timing. An accepted word sits in the input register while the parser and comparator
// evaluate it; its response is registered into the output register at the edge that
// moves the word on, and the parse state advances at that same edge. Unless a response
// stalls, one word is taken every cycle: throughput is one word per cycle.
// Stalls. When a response waits in the output register and rsp_ready is low, a word in
// the input register that would produce a response holds there and req_ready falls;
// words that produce no response still move through. Nothing is dropped or repeated.
// Reset. arst_n clears both registers' valid flags and the parse state; no filter is
// loaded, so compares answer "no filter loaded" until a text is accepted.
module size_filter_parse_and_compare (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sfpc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sfpc_pkg::rsp_t rsp
);
	import sfpc_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	filt_t filt;
	logic  text_ok;
	logic  hit;
	logic  has_rsp;
	logic  advance;
	rsp_t  rsp_next;

	// A compare always answers; a text unit answers only when it ends the text.
	assign has_rsp   = (req_s1.opcode == OP_COMPARE) || req_s1.text_end;
	assign advance   = valid_s1 && (!has_rsp || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	sfpc_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (req_s1),
		.filt    (filt),
		.text_ok (text_ok)
	);

	sfpc_match u_match (
		.filt      (filt),
		.file_size (req_s1.file_size),
		.hit       (hit)
	);

	always_comb begin
		if (req_s1.opcode == OP_COMPARE) begin
			rsp_next.status      = filt.loaded ? ST_COMPARED : ST_NO_FILTER;
			rsp_next.matches_res = filt.loaded && hit;
		end else begin
			rsp_next.status      = text_ok ? ST_ACCEPT : ST_REJECT;
			rsp_next.matches_res = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && has_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_rsp) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/core/sfpc_checker.sv
// Port-level checker for the size filter parser and comparator, bound to the top level.
// Depends on sfpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfpc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input sfpc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sfpc_pkg::rsp_t rsp
);
	import sfpc_pkg::*;

	// A waiting response word holds until taken.
	`SFPC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response word changed while stalled")

	// Input back-pressure only comes from a stalled response.
	`SFPC_ASSERT_IMP(a_stall_cause, clk, arst_n, !req_ready, rsp_valid && !rsp_ready, "request stalled without a stalled response")

	// Text results never report a match.
	`SFPC_ASSERT_IMP(a_text_no_match, clk, arst_n, rsp_valid && (rsp.status == ST_ACCEPT || rsp.status == ST_REJECT), !rsp.matches_res, "text result carries a match")

	// Without a filter there is no match.
	`SFPC_ASSERT_IMP(a_nofilt_no_match, clk, arst_n, rsp_valid && rsp.status == ST_NO_FILTER, !rsp.matches_res, "match reported with no filter loaded")

endmodule

bind size_filter_parse_and_compare sfpc_checker u_sfpc_checker (.*);

>>> dv/tb_size_filter_parse_and_compare.sv
// Self-checking testbench for size_filter_parse_and_compare: filter text parsing and size compares.
// Depends on sfpc_pkg and the RTL top level; drives both valid/ready channels with random stalls.
// Responses are checked against an in-bench model of the parser and comparator.
module tb_size_filter_parse_and_compare;
	import sfpc_pkg::*;

	// Cycle limit. The whole run stays far below it even with every stall,
	// so this leaves a large margin.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 300;
	localparam int HOLD_CYCLES = 80;
	localparam logic [63:0] ALL_ONES = '1;

	// Kinds of directed rows: a whole text, a text left open (no end mark), a compare.
	localparam logic [1:0] K_TEXT = 2'd0;
	localparam logic [1:0] K_PART = 2'd1;
	localparam logic [1:0] K_CMP  = 2'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	size_filter_parse_and_compare dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// Model of the filter. The f_ state mirrors the parse state of the block and
	// the active filter; it advances once per accepted word, in acceptance order.
	phase_t      f_phase;
	mode_t       f_mode;
	suffix_t     f_suf;
	logic [63:0] f_low;
	logic [63:0] f_high;
	logic [63:0] f_num;
	bit          f_dot;
	bit          f_range;
	bit          f_err;
	bit          f_loaded;

	rsp_t        owed_rsp[$];
	rsp_t        owed_head;
	logic [15:0] text_units[$];
	int          mismatches = 0;
	int          word_count = 0;
	int unsigned cycles = 0;
	bit          calm = 1'b0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	// Forgets the partial text. The active filter (mode and bounds) is kept.
	function automatic void clear_text();
		f_phase = PH_START;
		f_num   = '0;
		f_suf   = SUF_NONE;
		f_dot   = 1'b0;
		f_range = 1'b0;
		f_err   = 1'b0;
	endfunction

	// Scales the number by its unit. Returns 0 on a bad unit or on overflow.
	function automatic bit scaled_bound(output logic [63:0] v);
		int sh;
		v = '0;
		case (f_suf)
			SUF_NONE, SUF_B: sh = 0;
			SUF_KB: sh = KB_SHIFT;
			SUF_MB: sh = MB_SHIFT;
			SUF_GB: sh = GB_SHIFT;
			default: return 1'b0;
		endcase
		if (sh != 0 && f_num > (ALL_ONES >> sh))
			return 1'b0;
		v = f_num << sh;
		return 1'b1;
	endfunction

	function automatic void take_digit(logic [15:0] c);
		logic [63:0] d;
		d = {48'h0, c - CH_0};
		if (f_num > (ALL_ONES - d) / 64'd10) begin
			f_err = 1'b1;
		end else begin
			f_num   = f_num * 64'd10 + d;
			f_phase = PH_DIGITS;
		end
	endfunction

	// Unit letters fold to lower case over ASCII only.
	function automatic void take_unit(logic [15:0] c);
		logic [15:0] lc;
		lc = c;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			lc = c + CASE_OFFSET;
		if (f_suf == SUF_NONE) begin
			if (lc == CH_B)
				f_suf = SUF_B;
			else if (lc == CH_K)
				f_suf = SUF_K;
			else if (lc == CH_M)
				f_suf = SUF_M;
			else if (lc == CH_G)
				f_suf = SUF_G;
			else begin
				f_err = 1'b1;
				return;
			end
		end else if (f_suf == SUF_K && lc == CH_B) begin
			f_suf = SUF_KB;
		end else if (f_suf == SUF_M && lc == CH_B) begin
			f_suf = SUF_MB;
		end else if (f_suf == SUF_G && lc == CH_B) begin
			f_suf = SUF_GB;
		end else begin
			f_err = 1'b1;
			return;
		end
		f_phase = PH_UNIT;
	endfunction

	// The second dot of "..": the first size becomes the low bound of a range.
	function automatic void split_range();
		logic [63:0] v;
		if (!scaled_bound(v)) begin
			f_err = 1'b1;
			return;
		end
		f_low   = v;
		f_num   = '0;
		f_suf   = SUF_NONE;
		f_range = 1'b1;
		f_mode  = MODE_RANGE;
		f_phase = PH_NEED_DIGIT;
	endfunction

	function automatic void take_char(logic [15:0] c);
		bit dig;
		dig = (c >= CH_0 && c <= CH_9);
		if (f_dot) begin
			f_dot = 1'b0;
			if (c == CH_DOT)
				split_range();
			else
				f_err = 1'b1;
			return;
		end
		case (f_phase)
			PH_START: begin
				f_mode = MODE_EQ;
				if (c == CH_GT) begin
					f_mode  = MODE_GT;
					f_phase = PH_PREFIX1;
				end else if (c == CH_LT) begin
					f_mode  = MODE_LT;
					f_phase = PH_PREFIX1;
				end else if (c == CH_EQ) begin
					f_mode  = MODE_EQ_EXPLICIT;
					f_phase = PH_NEED_DIGIT;
				end else if (dig) begin
					take_digit(c);
				end else begin
					f_err = 1'b1;
				end
			end
			PH_PREFIX1: begin
				if (c == CH_EQ) begin
					f_mode  = (f_mode == MODE_GT) ? MODE_GE : MODE_LE;
					f_phase = PH_NEED_DIGIT;
				end else if (dig) begin
					take_digit(c);
				end else begin
					f_err = 1'b1;
				end
			end
			PH_NEED_DIGIT: begin
				if (dig)
					take_digit(c);
				else
					f_err = 1'b1;
			end
			PH_DIGITS, PH_UNIT: begin
				// A dot may only open a range: plain mode and no range yet.
				if (c == CH_DOT) begin
					if (f_mode == MODE_EQ && !f_range)
						f_dot = 1'b1;
					else
						f_err = 1'b1;
				end else if (dig) begin
					if (f_phase == PH_DIGITS)
						take_digit(c);
					else
						f_err = 1'b1;
				end else begin
					take_unit(c);
				end
			end
			default: f_err = 1'b1;
		endcase
	endfunction

	// End of text: decides whether the text becomes the active filter.
	function automatic bit close_text();
		bit ok;
		logic [63:0] v;
		v  = '0;
		ok = !f_err && !f_dot && (f_phase == PH_DIGITS || f_phase == PH_UNIT);
		if (ok)
			ok = scaled_bound(v);
		if (!ok)
			return 1'b0;
		if (f_range) begin
			if (f_low > v)
				return 1'b0;
			f_high = v;
		end else begin
			f_low  = v;
			f_high = '0;
		end
		return 1'b1;
	endfunction

	function automatic bit size_hit(logic [63:0] s);
		case (f_mode)
			MODE_EQ, MODE_EQ_EXPLICIT: return s == f_low;
			MODE_GT: return s > f_low;
			MODE_GE: return s >= f_low;
			MODE_LT: return s < f_low;
			MODE_LE: return s <= f_low;
			MODE_RANGE: return s >= f_low && s <= f_high;
			default: return 1'b0;
		endcase
	endfunction

	// One accepted word: advances the model and says whether a response is owed.
	function automatic void parse_or_compare(input req_t w, output bit has, output rsp_t r);
		has = 1'b0;
		r   = '0;
		if (w.opcode == OP_COMPARE) begin
			has = 1'b1;
			if (f_loaded) begin
				r.status      = ST_COMPARED;
				r.matches_res = size_hit(w.file_size);
			end else begin
				r.status = ST_NO_FILTER;
			end
			return;
		end
		// Any text unit drops the active filter at once.
		f_loaded = 1'b0;
		if (!f_err)
			take_char(w.text_unit);
		if (!w.text_end)
			return;
		f_loaded = close_text();
		has      = 1'b1;
		r.status = f_loaded ? ST_ACCEPT : ST_REJECT;
		clear_text();
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	function automatic req_t text_word(logic [15:0] c, bit last);
		req_t w;
		w.opcode    = OP_TEXT;
		w.text_unit = c;
		w.text_end  = last;
		w.file_size = {$urandom, $urandom};
		return w;
	endfunction

	// The text fields of a compare word are noise; the block must ignore them.
	function automatic req_t cmp_word(logic [63:0] s);
		req_t w;
		w.opcode    = OP_COMPARE;
		w.text_unit = 16'($urandom);
		w.text_end  = 1'($urandom);
		w.file_size = s;
		return w;
	endfunction

	// Candidate sizes sit mostly at the edges of the active filter.
	function automatic logic [63:0] pick_size();
		case ($urandom_range(7))
			0: return f_low;
			1: return f_low + 64'd1;
			2: return f_low - 64'd1;
			3: return f_high;
			4: return f_high + 64'd1;
			5: return '0;
			6: return ALL_ONES;
			default: return {$urandom, $urandom} >> $urandom_range(63);
		endcase
	endfunction

	// Offers one word and waits for it to be taken. An expectation typed into the
	// directed table replaces the model's answer for that word.
	task automatic send_word(req_t w, bit typed, rsp_t fixed);
		bit has;
		rsp_t r;
		if (!calm && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		word_count++;
		parse_or_compare(w, has, r);
		if (has)
			owed_rsp.insert(owed_rsp.size(), typed ? fixed : r);
	endtask

	// Sends text_units; with mix set, compares now and then cut into the text.
	task automatic send_text(bit closed, bit typed, rsp_t fixed, bit mix);
		int n;
		n = text_units.size();
		for (int i = 0; i < n; i++) begin
			if (mix && $urandom_range(99) < 4)
				send_word(cmp_word(pick_size()), 1'b0, '0);
			send_word(text_word(text_units[i], closed && i == n - 1), typed && i == n - 1, fixed);
		end
	endtask

	function automatic void push_text(string s);
		foreach (s[i])
			text_units.insert(text_units.size(), {8'h00, s[i]});
	endfunction

	function automatic void push_letter(byte ch);
		if ($urandom_range(1))
			ch = ch - 8'h20;
		text_units.insert(text_units.size(), {8'h00, ch});
	endfunction

	// Unit 0 is none, then b, kb, mb and gb, each letter in random case.
	function automatic void push_suffix(int k);
		case (k)
			1: push_letter("b");
			2: begin
				push_letter("k");
				push_letter("b");
			end
			3: begin
				push_letter("m");
				push_letter("b");
			end
			4: begin
				push_letter("g");
				push_letter("b");
			end
			default: ;
		endcase
	endfunction

	// Mostly short numbers; some 17 to 21 digits long to cross the 64-bit limit.
	function automatic void push_number();
		string s;
		int n;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: s = $sformatf("%0d", $urandom_range(999));
			6, 7: s = $sformatf("%0d", $urandom);
			default: begin
				n = $urandom_range(17, 21);
				s = $urandom_range(1) ? "1" : "";
				while (s.len() < n)
					s = {s, $sformatf("%0d", $urandom_range(9))};
			end
		endcase
		push_text(s);
	endfunction

	// Builds one random text: 70% well formed (ranges and prefixed sizes),
	// 15% well formed then broken in one place, 15% plain noise.
	task automatic build_text();
		int r;
		int k;
		int lo;
		int hi;
		int pos;
		text_units.delete();
		r = $urandom_range(99);
		if (r < 85) begin
			if ($urandom_range(3) == 0) begin
				lo = $urandom_range(5000);
				hi = ($urandom_range(4) != 0) ? lo + $urandom_range(3000) : $urandom_range(5000);
				k  = $urandom_range(4);
				push_text($sformatf("%0d", lo));
				push_suffix(k);
				push_text("..");
				push_text($sformatf("%0d", hi));
				push_suffix(($urandom_range(3) == 0) ? $urandom_range(4) : k);
			end else begin
				case ($urandom_range(5))
					1: push_text("=");
					2: push_text(">");
					3: push_text("<");
					4: push_text(">=");
					5: push_text("<=");
					default: ;
				endcase
				push_number();
				push_suffix($urandom_range(4));
			end
			if (r >= 70) begin
				pos = $urandom_range(text_units.size() - 1);
				case ($urandom_range(2))
					0: text_units[pos] = {8'h00, 8'($urandom_range(32, 126))};
					1: text_units.insert(pos, CH_DOT);
					default: if (text_units.size() > 1) text_units.pop_back();
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 4))
				text_units.insert(text_units.size(),
					$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(32, 126)));
		end
	endtask

	// Directed table. In the text column '#' stands for the wide code unit of the row.
	// Rows with the typed flag carry their expected response; the others are checked
	// against the model.
	typedef struct packed {
		logic [1:0]  kind;
		logic        typed;
		status_t     st;
		logic        hit;
		logic [63:0] size;
		logic [15:0] wide;
	} dir_row_t;

	localparam int N_DIR = 32;

	string dir_text [N_DIR] = '{
		"", "18446744073709551615", "", "18446744073709551616", "",
		">=1kb", "", "<=2MB", "", ">7gB",
		"", "<5b", "", "=0", "17179869183Gb",
		"17179869184gb", "3..4kb", "", "5..2", "1.5",
		"1.", ">1..2", "1..2..3", "1#", "#",
		"1kbb", "4", "", "2", "",
		"<", "=5..6"
	};

	dir_row_t dir_tab [N_DIR] = '{
		// Compare before any filter was loaded.
		'{K_CMP,  1'b1, ST_NO_FILTER, 1'b0, 64'd0, 16'h0},
		// Largest size that fits in 64 bits, then one past it.
		'{K_TEXT, 1'b1, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b1, ST_COMPARED,  1'b1, ALL_ONES, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		// A rejected text leaves no active filter.
		'{K_CMP,  1'b1, ST_NO_FILTER, 1'b0, ALL_ONES, 16'h0},
		'{K_TEXT, 1'b1, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd1024, 16'h0},
		'{K_TEXT, 1'b0, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd2097153, 16'h0},
		'{K_TEXT, 1'b0, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd7516192769, 16'h0},
		'{K_TEXT, 1'b0, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd4, 16'h0},
		'{K_TEXT, 1'b0, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		// Largest gigabyte count that scales without overflow, then one past it.
		'{K_TEXT, 1'b1, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd4096, 16'h0},
		// Reversed range, single dots, prefix with a range, dots after the split.
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		// Non-ASCII units, one whose low byte looks like a digit; then a doubled unit letter.
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0131},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'hFFFF},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		// A compare in the middle of a text sees no filter.
		'{K_PART, 1'b0, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b1, ST_NO_FILTER, 1'b0, 64'd4, 16'h0},
		'{K_TEXT, 1'b1, ST_ACCEPT,    1'b0, 64'd0, 16'h0},
		'{K_CMP,  1'b0, ST_ACCEPT,    1'b0, 64'd42, 16'h0},
		// A text that ends on its prefix, and "=" before a range.
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0},
		'{K_TEXT, 1'b1, ST_REJECT,    1'b0, 64'd0, 16'h0}
	};

	// Response side. Ready idles at random, or is held low for a long stretch
	// each time the stimulus bumps hold_token.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	// Each response word taken is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_rsp.size() == 0) begin
				report_mismatch($sformatf("response with none owed, status %0d", rsp.status));
			end else begin
				owed_head = owed_rsp.pop_front();
				if (rsp.status !== owed_head.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, owed_head.status));
				if (rsp.matches_res !== owed_head.matches_res)
					report_mismatch($sformatf("matches_res %0b, expected %0b",
						rsp.matches_res, owed_head.matches_res));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int base;
		string s;
		dir_row_t row;
		rsp_t fixed;

		f_mode   = MODE_EQ;
		f_low    = '0;
		f_high   = '0;
		f_loaded = 1'b0;
		clear_text();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		for (int i = 0; i < N_DIR; i++) begin
			row   = dir_tab[i];
			s     = dir_text[i];
			fixed = '0;
			fixed.status      = row.st;
			fixed.matches_res = row.hit;
			if (row.kind == K_CMP) begin
				send_word(cmp_word(row.size), row.typed, fixed);
			end else begin
				text_units.delete();
				foreach (s[j])
					text_units.insert(text_units.size(),
						(s[j] == "#") ? row.wide : {8'h00, s[j]});
				send_text(row.kind == K_TEXT, row.typed, fixed, 1'b0);
			end
		end

		// Let every owed response come back before the back-pressure test.
		req_valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);

		// Hold the response side while compares keep coming, so the block fills
		// and has to drop req_ready.
		hold_token <= hold_token + 1;
		calm = 1'b1;
		repeat (12)
			send_word(cmp_word(pick_size()), 1'b0, '0);
		calm = 1'b0;

		// Random part, with a stretch in the middle where neither side idles.
		base = word_count;
		while (word_count - base < RANDOM_WORDS) begin
			calm = (word_count - base > 150) && (word_count - base < 260);
			build_text();
			send_text(1'b1, 1'b0, '0, 1'b1);
			repeat ($urandom_range(3))
				send_word(cmp_word(pick_size()), 1'b0, '0);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		// Drain, then go on clocking to catch any stray response.
		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
